// File: src/lswc_pkg.sv
// ============================================================================
// lswc_pkg
// Shared types and constants for the line segment window clipper.
// ============================================================================
package lswc_pkg;

    localparam int CW = 16;                 // coordinate width
    localparam int DW = CW + 1;             // difference width
    localparam int PW = 2 * DW;             // product width
    localparam int QCW = $clog2(PW + 1);    // divider step counter width
    localparam int MAX_STEPS = 4;
    localparam int STW = $clog2(MAX_STEPS + 1);

    localparam logic [3:0] CODE_LEFT   = 4'd1;
    localparam logic [3:0] CODE_RIGHT  = 4'd2;
    localparam logic [3:0] CODE_BOTTOM = 4'd4;
    localparam logic [3:0] CODE_TOP    = 4'd8;

    localparam logic [1:0] REG_LEFT   = 2'd0;
    localparam logic [1:0] REG_BOTTOM = 2'd1;
    localparam logic [1:0] REG_RIGHT  = 2'd2;
    localparam logic [1:0] REG_TOP    = 2'd3;

    typedef enum logic [2:0] {
        CMD_NONE,
        CMD_LOAD,
        CMD_SETUP,
        CMD_MUL,
        CMD_DIV,
        CMD_APPLY
    } cmd_t;

    typedef struct packed {
        logic       both_in;
        logic       trivial_out;
        logic       div_done;
    } status_t;

endpackage

// File: src/line_segment_window_clipper.sv
// A trivial decision passes from input word to result word through the load and
//   test states; each clip step adds setup, operand select, multiply, a serial
//   divide and apply, with at most 4 steps per segment.
// One segment at a time; the next word is taken the cycle after the result word
//   leaves.
// Reset (rst_n low, async) restores the default window.
// ============================================================================
// line_segment_window_clipper
// Cohen-Sutherland clipping of one segment against a configurable window.
// ============================================================================
module line_segment_window_clipper
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,   // start_x, start_y, end_x, end_y
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [63:0] m_axis_tdata,   // clip_start_x, clip_start_y, clip_end_x, clip_end_y
    output logic        m_axis_tuser    // accepted
);

    lswc_pkg::cmd_t    cmd;
    lswc_pkg::status_t status;
    logic busy, rvalid, racc, in_fire, out_fire;
    logic signed [lswc_pkg::CW-1:0] x1, y1, x2, y2;

    assign cfg_ready     = 1'b1;
    assign s_axis_tready = !busy;
    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign out_fire      = m_axis_tvalid && m_axis_tready;

    lswc_ctrl u_ctrl
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_fire      (in_fire),
        .out_fire     (out_fire),
        .status       (status),
        .cmd          (cmd),
        .busy         (busy),
        .result_valid (rvalid),
        .result_acc   (racc)
    );

    lswc_dp u_dp
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg_we  (cfg_valid),
        .cfg_idx (cfg_index),
        .cfg_val (cfg_data),
        .in_x1   (s_axis_tdata[15:0]),
        .in_y1   (s_axis_tdata[31:16]),
        .in_x2   (s_axis_tdata[47:32]),
        .in_y2   (s_axis_tdata[63:48]),
        .cmd     (cmd),
        .status  (status),
        .x1      (x1),
        .y1      (y1),
        .x2      (x2),
        .y2      (y2)
    );

    assign m_axis_tvalid = rvalid;
    assign m_axis_tuser  = racc;
    assign m_axis_tdata  = racc ? {y2, x2, y1, x1} : 64'd0;

    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        busy |-> !s_axis_tready) else $error("input taken while busy");
    a_hold_result: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
        else $error("result dropped");
    a_busy_after_in: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |=> busy) else $error("input lost");

endmodule

// File: src/lswc_ctrl.sv
// ============================================================================
// lswc_ctrl
// Sequencer for the clipping loop: load, test, multiply, divide, apply.
// ============================================================================
module lswc_ctrl
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_fire,
    input  logic               out_fire,
    input  lswc_pkg::status_t  status,
    output lswc_pkg::cmd_t     cmd,
    output logic               busy,
    output logic               result_valid,
    output logic               result_acc
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_TEST,
        S_PREP,
        S_MUL,
        S_DIV,
        S_APPLY,
        S_DONE
    } state_t;

    state_t                    state_reg, state_next;
    logic [lswc_pkg::STW-1:0]  steps_reg, steps_next;
    logic                      acc_reg, acc_next;

    always_comb
    begin
        state_next = state_reg;
        steps_next = steps_reg;
        acc_next   = acc_reg;
        cmd        = lswc_pkg::CMD_NONE;
        case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    cmd        = lswc_pkg::CMD_LOAD;
                    steps_next = '0;
                    state_next = S_TEST;
                end
            end
            S_TEST:
            begin
                if (status.both_in)
                begin
                    acc_next   = 1'b1;
                    state_next = S_DONE;
                end
                else if (status.trivial_out ||
                         steps_reg == lswc_pkg::STW'(lswc_pkg::MAX_STEPS))
                begin
                    acc_next   = 1'b0;
                    state_next = S_DONE;
                end
                else
                begin
                    cmd        = lswc_pkg::CMD_SETUP;
                    state_next = S_PREP;
                end
            end
            S_PREP:
            begin
                state_next = S_MUL;
            end
            S_MUL:
            begin
                cmd        = lswc_pkg::CMD_MUL;
                state_next = S_DIV;
            end
            S_DIV:
            begin
                cmd = lswc_pkg::CMD_DIV;
                if (status.div_done)
                begin
                    state_next = S_APPLY;
                end
            end
            S_APPLY:
            begin
                cmd        = lswc_pkg::CMD_APPLY;
                steps_next = steps_reg + 1'b1;
                state_next = S_TEST;
            end
            S_DONE:
            begin
                if (out_fire)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            steps_reg <= '0;
            acc_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            steps_reg <= steps_next;
            acc_reg   <= acc_next;
        end
    end

    assign busy         = (state_reg != S_IDLE);
    assign result_valid = (state_reg == S_DONE);
    assign result_acc   = acc_reg;

endmodule

// File: src/lswc_dp.sv
// ============================================================================
// lswc_dp
// Clipping datapath: window registers, endpoints, outcodes, multiplier and
// a restoring divider one quotient bit per cycle.
// ============================================================================
module lswc_dp
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_we,
    input  logic [1:0]                  cfg_idx,
    input  logic signed [lswc_pkg::CW-1:0] cfg_val,
    input  logic signed [lswc_pkg::CW-1:0] in_x1,
    input  logic signed [lswc_pkg::CW-1:0] in_y1,
    input  logic signed [lswc_pkg::CW-1:0] in_x2,
    input  logic signed [lswc_pkg::CW-1:0] in_y2,
    input  lswc_pkg::cmd_t              cmd,
    output lswc_pkg::status_t           status,
    output logic signed [lswc_pkg::CW-1:0] x1,
    output logic signed [lswc_pkg::CW-1:0] y1,
    output logic signed [lswc_pkg::CW-1:0] x2,
    output logic signed [lswc_pkg::CW-1:0] y2
);

    localparam int CW  = lswc_pkg::CW;
    localparam int DW  = lswc_pkg::DW;
    localparam int PW  = lswc_pkg::PW;
    localparam int QCW = lswc_pkg::QCW;

    logic signed [CW-1:0] wl_reg, wb_reg, wr_reg, wt_reg;
    logic signed [CW-1:0] x1_reg, y1_reg, x2_reg, y2_reg;
    logic signed [DW-1:0] ma_reg, mb_reg, md_reg;
    logic signed [CW-1:0] base_reg, edge_reg;
    logic                 vert_reg, first_reg, neg_reg;
    logic [PW-1:0]        num_reg;
    logic [DW-1:0]        den_reg;
    logic [DW:0]          rem_reg;
    logic [PW-1:0]        quo_reg;
    logic [QCW-1:0]       cnt_reg;

    logic [3:0] c1, c2, co;
    logic signed [CW-1:0] px1, py1, px2, py2;
    logic signed [PW-1:0] prod;
    logic [DW:0]          rem_sh;
    logic [PW-1:0]        qs;
    logic signed [CW-1:0] moved;

    function automatic logic [3:0] outcode(
        input logic signed [CW-1:0] x, input logic signed [CW-1:0] y,
        input logic signed [CW-1:0] l, input logic signed [CW-1:0] r,
        input logic signed [CW-1:0] b, input logic signed [CW-1:0] t);
        logic [3:0] c;
        c = '0;
        if (x < l)
            c = c | lswc_pkg::CODE_LEFT;
        else if (x > r)
            c = c | lswc_pkg::CODE_RIGHT;
        if (y < b)
            c = c | lswc_pkg::CODE_BOTTOM;
        else if (y > t)
            c = c | lswc_pkg::CODE_TOP;
        return c;
    endfunction

    assign c1 = outcode(x1_reg, y1_reg, wl_reg, wr_reg, wb_reg, wt_reg);
    assign c2 = outcode(x2_reg, y2_reg, wl_reg, wr_reg, wb_reg, wt_reg);
    assign co = (c1 != 4'd0) ? c1 : c2;

    assign status.both_in     = (c1 == 4'd0) && (c2 == 4'd0);
    assign status.trivial_out = ((c1 & c2) != 4'd0);
    assign status.div_done    = (cnt_reg == '0);

    // intersection always measured from the first endpoint
    assign px1 = x1_reg;
    assign py1 = y1_reg;
    assign px2 = x2_reg;
    assign py2 = y2_reg;

    assign prod   = ma_reg * mb_reg;
    assign rem_sh = {rem_reg[DW-1:0], num_reg[PW-1]};
    assign qs     = neg_reg ? (~quo_reg + 1'b1) : quo_reg;
    assign moved  = CW'(base_reg + CW'(qs));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wl_reg  <= '0;
            wb_reg  <= '0;
            wr_reg  <= CW'(639);
            wt_reg  <= CW'(479);
            cnt_reg <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_idx)
                    lswc_pkg::REG_LEFT:   wl_reg <= cfg_val;
                    lswc_pkg::REG_BOTTOM: wb_reg <= cfg_val;
                    lswc_pkg::REG_RIGHT:  wr_reg <= cfg_val;
                    lswc_pkg::REG_TOP:    wt_reg <= cfg_val;
                    default:              wl_reg <= wl_reg;
                endcase
            end
            if (cmd == lswc_pkg::CMD_MUL)
                cnt_reg <= QCW'(PW);
            else if (cmd == lswc_pkg::CMD_DIV && cnt_reg != '0)
                cnt_reg <= cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        case (cmd)
            lswc_pkg::CMD_LOAD:
            begin
                x1_reg <= in_x1;
                y1_reg <= in_y1;
                x2_reg <= in_x2;
                y2_reg <= in_y2;
            end
            lswc_pkg::CMD_SETUP:
            begin
                first_reg <= (c1 != 4'd0);
                if ((co & lswc_pkg::CODE_TOP) != 4'd0)
                begin
                    vert_reg <= 1'b0;
                    edge_reg <= wt_reg;
                end
                else if ((co & lswc_pkg::CODE_BOTTOM) != 4'd0)
                begin
                    vert_reg <= 1'b0;
                    edge_reg <= wb_reg;
                end
                else if ((co & lswc_pkg::CODE_RIGHT) != 4'd0)
                begin
                    vert_reg <= 1'b1;
                    edge_reg <= wr_reg;
                end
                else
                begin
                    vert_reg <= 1'b1;
                    edge_reg <= wl_reg;
                end
            end
            lswc_pkg::CMD_MUL:
            begin
                num_reg <= prod[PW-1] ? PW'(-prod) : PW'(prod);
                den_reg <= md_reg[DW-1] ? DW'(-md_reg) : DW'(md_reg);
                neg_reg <= (prod[PW-1] != md_reg[DW-1]) && (prod != '0) && (md_reg != '0);
                rem_reg <= '0;
                quo_reg <= '0;
                base_reg <= vert_reg ? py1 : px1;
            end
            lswc_pkg::CMD_DIV:
            begin
                if (cnt_reg != '0)
                begin
                    num_reg <= {num_reg[PW-2:0], 1'b0};
                    if (den_reg != '0 && rem_sh >= {1'b0, den_reg})
                    begin
                        rem_reg <= rem_sh - {1'b0, den_reg};
                        quo_reg <= {quo_reg[PW-2:0], 1'b1};
                    end
                    else
                    begin
                        rem_reg <= rem_sh;
                        quo_reg <= {quo_reg[PW-2:0], 1'b0};
                    end
                end
            end
            lswc_pkg::CMD_APPLY:
            begin
                if (first_reg)
                begin
                    x1_reg <= vert_reg ? edge_reg : moved;
                    y1_reg <= vert_reg ? moved : edge_reg;
                end
                else
                begin
                    x2_reg <= vert_reg ? edge_reg : moved;
                    y2_reg <= vert_reg ? moved : edge_reg;
                end
            end
            default:
            begin
                num_reg <= num_reg;
            end
        endcase
    end

    // operand selection from the setup decision, registered ahead of the multiply
    always_ff @(posedge clk)
    begin
        if (vert_reg)
        begin
            ma_reg <= DW'(py2) - DW'(py1);
            mb_reg <= DW'(edge_reg) - DW'(px1);
            md_reg <= DW'(px2) - DW'(px1);
        end
        else
        begin
            ma_reg <= DW'(px2) - DW'(px1);
            mb_reg <= DW'(edge_reg) - DW'(py1);
            md_reg <= DW'(py2) - DW'(py1);
        end
    end

    assign x1 = x1_reg;
    assign y1 = y1_reg;
    assign x2 = x2_reg;
    assign y2 = y2_reg;

endmodule

// File: verif/testbench.sv
// ============================================================================
// Line segment window clipper testbench
// Drives segments and window settings into the clipper, predicts each clipped
// result with an outcode clipping model and compares every output word.
// ============================================================================
module testbench;

    localparam int TIMEOUT_CYCLES = 1500000;

    typedef struct packed {
        logic           accepted;
        logic [15:0]    sx;
        logic [15:0]    sy;
        logic [15:0]    ex;
        logic [15:0]    ey;
    } clip_result_t;

    logic           clk;
    logic           rst_n;
    logic           cfg_valid;
    logic           cfg_ready;
    logic [1:0]     cfg_index;
    logic [15:0]    cfg_data;
    logic           s_axis_tvalid;
    logic           s_axis_tready;
    logic [63:0]    s_axis_tdata;
    logic           m_axis_tvalid;
    logic           m_axis_tready;
    logic [63:0]    m_axis_tdata;
    logic           m_axis_tuser;

    longint         win_left;
    longint         win_bottom;
    longint         win_right;
    longint         win_top;
    clip_result_t   clip_queue[$];
    int             errors = 0;
    int             cycles = 0;
    bit             idle_en;

    line_segment_window_clipper u_dut
    (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .m_axis_tuser(m_axis_tuser)
    );

    always
    begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    function automatic longint sext16(longint v);
        logic [15:0] t;
        t = v[15:0];
        return longint'($signed(t));
    endfunction

    function automatic logic [3:0] region_code(longint x, longint y);
        logic [3:0] c;
        c = '0;
        if (x < win_left)
            c |= lswc_pkg::CODE_LEFT;
        else if (x > win_right)
            c |= lswc_pkg::CODE_RIGHT;
        if (y < win_bottom)
            c |= lswc_pkg::CODE_BOTTOM;
        else if (y > win_top)
            c |= lswc_pkg::CODE_TOP;
        return c;
    endfunction

    // truncating signed division of a product; operands are small enough
    function automatic longint scaled_delta(longint a, longint b, longint d);
        if (d == 0)
            return 0;
        return (a * b) / d;
    endfunction

    function automatic clip_result_t clip_segment(longint x1, longint y1,
                                                  longint x2, longint y2);
        clip_result_t r;
        logic [3:0]   c1;
        logic [3:0]   c2;
        logic [3:0]   co;
        longint       x;
        longint       y;
        int           steps;
        bit           acc;
        c1 = region_code(x1, y1);
        c2 = region_code(x2, y2);
        steps = 0;
        acc = 0;
        forever
        begin
            if (c1 == 0 && c2 == 0)
            begin
                acc = 1;
                break;
            end
            if ((c1 & c2) != 0 || steps >= lswc_pkg::MAX_STEPS)
                break;
            co = (c1 != 0) ? c1 : c2;
            if (co & lswc_pkg::CODE_TOP)
            begin
                x = x1 + scaled_delta(x2 - x1, win_top - y1, y2 - y1);
                y = win_top;
            end
            else if (co & lswc_pkg::CODE_BOTTOM)
            begin
                x = x1 + scaled_delta(x2 - x1, win_bottom - y1, y2 - y1);
                y = win_bottom;
            end
            else if (co & lswc_pkg::CODE_RIGHT)
            begin
                y = y1 + scaled_delta(y2 - y1, win_right - x1, x2 - x1);
                x = win_right;
            end
            else
            begin
                y = y1 + scaled_delta(y2 - y1, win_left - x1, x2 - x1);
                x = win_left;
            end
            x = sext16(x);
            y = sext16(y);
            if (co == c1)
            begin
                x1 = x;
                y1 = y;
                c1 = region_code(x1, y1);
            end
            else
            begin
                x2 = x;
                y2 = y;
                c2 = region_code(x2, y2);
            end
            steps++;
        end
        r.accepted = acc;
        r.sx = acc ? x1[15:0] : '0;
        r.sy = acc ? y1[15:0] : '0;
        r.ex = acc ? x2[15:0] : '0;
        r.ey = acc ? y2[15:0] : '0;
        return r;
    endfunction

    task automatic idle_gap();
        if (idle_en && $urandom_range(0, 3) == 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(negedge clk);
        end
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        while (clip_queue.size() != 0)
            @(negedge clk);
        repeat (200) @(negedge clk);
    endtask

    task automatic write_window(logic [1:0] idx, logic [15:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        @(negedge clk);
        case (idx)
            lswc_pkg::REG_LEFT:   win_left = longint'($signed(val));
            lswc_pkg::REG_BOTTOM: win_bottom = longint'($signed(val));
            lswc_pkg::REG_RIGHT:  win_right = longint'($signed(val));
            default:              win_top = longint'($signed(val));
        endcase
    endtask

    task automatic set_window(int l, int b, int r, int t);
        wait_drained();
        write_window(lswc_pkg::REG_LEFT, l[15:0]);
        write_window(lswc_pkg::REG_BOTTOM, b[15:0]);
        write_window(lswc_pkg::REG_RIGHT, r[15:0]);
        write_window(lswc_pkg::REG_TOP, t[15:0]);
        cfg_valid <= 1'b0;
    endtask

    task automatic send_segment(int x1, int y1, int x2, int y2);
        idle_gap();
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {y2[15:0], x2[15:0], y1[15:0], x1[15:0]};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        clip_queue.push_back(clip_segment(sext16(x1), sext16(y1),
                                          sext16(x2), sext16(y2)));
        @(negedge clk);
    endtask

    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            clip_result_t got;
            clip_result_t exp;
            got = {m_axis_tuser, m_axis_tdata[15:0], m_axis_tdata[31:16],
                   m_axis_tdata[47:32], m_axis_tdata[63:48]};
            if (clip_queue.size() == 0)
            begin
                $display("%0t: unexpected word %h", $time, got);
                errors++;
            end
            else
            begin
                exp = clip_queue.pop_front();
                if (got.accepted !== exp.accepted || got.sx !== exp.sx ||
                    got.sy !== exp.sy || got.ex !== exp.ex || got.ey !== exp.ey)
                begin
                    $display("%0t: expected acc=%b %h %h %h %h actual acc=%b %h %h %h %h",
                             $time, exp.accepted, exp.sx, exp.sy, exp.ex, exp.ey,
                             got.accepted, got.sx, got.sy, got.ex, got.ey);
                    errors++;
                end
            end
        end
    end

    always @(negedge clk)
    begin
        if (idle_en && $urandom_range(0, 5) == 0)
        begin
            m_axis_tready <= 1'b0;
            repeat ($urandom_range(1, 14)) @(negedge clk);
        end
        m_axis_tready <= 1'b1;
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > TIMEOUT_CYCLES)
        begin
            $display("** line_segment_window_clipper: FAILED **");
            $finish;
        end
    end

    function automatic int rand_coord();
        case ($urandom_range(0, 3))
            0:       return $signed($urandom_range(0, 65535)) - 32768;
            1:       return $urandom_range(0, 1) ? 32767 : -32768;
            default: return $signed($urandom_range(0, 1400)) - 400;
        endcase
    endfunction

    task automatic test_directed();
        send_segment(10, 10, 600, 400);
        send_segment(-100, 240, 800, 240);
        send_segment(320, -50, 320, 600);
        send_segment(-10, -10, -5, -20);
        send_segment(700, 10, 900, 400);
        send_segment(-200, 500, 300, 700);
        send_segment(-100, -100, 800, 600);
        send_segment(-32768, -32768, 32767, 32767);
        send_segment(32767, -32768, -32768, 32767);
        send_segment(-32768, 100, 32767, 100);
        send_segment(0, 0, 639, 479);
        send_segment(-1, 480, 640, -1);
        send_segment(-50, 200, 100, 600);
        send_segment(700, -100, 500, 300);
    endtask

    task automatic test_windows();
        set_window(-32768, -32768, 32767, 32767);
        send_segment(-32768, -32768, 32767, 32767);
        send_segment(-5, 3, 12, -9);
        set_window(100, 100, 100, 100);
        send_segment(0, 0, 200, 200);
        send_segment(0, 100, 200, 100);
        // inverted window
        set_window(500, 400, 100, 50);
        send_segment(0, 0, 600, 450);
        send_segment(300, 200, 301, 201);
        set_window(32767, 32767, -32768, -32768);
        send_segment(0, 0, 1, 1);
        set_window(-300, -200, 300, 200);
        send_segment(-32768, 32767, 32767, -32768);
        send_segment(-400, 0, 400, 10);
    endtask

    task automatic test_random(int count);
        int l;
        int b;
        for (int i = 0; i < count; i++)
        begin
            if (i % 150 == 0)
            begin
                l = $signed($urandom_range(0, 1000)) - 500;
                b = $signed($urandom_range(0, 1000)) - 500;
                if ($urandom_range(0, 5) == 0)
                    set_window(rand_coord(), rand_coord(), rand_coord(), rand_coord());
                else
                    set_window(l, b, l + $urandom_range(0, 1000), b + $urandom_range(0, 800));
            end
            if (i == count / 2)
                wait_drained();
            send_segment(rand_coord(), rand_coord(), rand_coord(), rand_coord());
        end
    endtask

    initial
    begin
        idle_en = 1;
        rst_n = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        win_left = 0;
        win_bottom = 0;
        win_right = 639;
        win_top = 479;
        repeat (6) @(negedge clk);
        rst_n = 1'b1;
        repeat (2) @(negedge clk);
        test_directed();
        test_windows();
        test_random(900);
        idle_en = 0;
        test_random(120);
        wait_drained();
        if (errors == 0)
            $display("** line_segment_window_clipper: PASSED **");
        else
            $display("** line_segment_window_clipper: FAILED **");
        $finish;
    end

endmodule
